// ----- rtl/tsvs_pkg.sv -----
// ----------------------------------------------------------------------------
// tsvs_pkg
// Shared sizes, register indexes and status codes for the tangent seam
// vertex splitter.
// ----------------------------------------------------------------------------
package tsvs_pkg;

    localparam int MAX_SOURCE_VERTICES = 1024;
    localparam int MAX_OUT_VERTICES    = 4096;
    localparam int MAX_VARIANTS        = 4;

    localparam int SRC_W = $clog2(MAX_SOURCE_VERTICES);
    localparam int OUT_W = $clog2(MAX_OUT_VERTICES);
    // allocator needs one extra bit to hold the table size itself
    localparam int NF_W  = OUT_W + 1;
    localparam int CNT_W = $clog2(MAX_VARIANTS + 1);
    localparam int K_W   = (MAX_VARIANTS > 1) ? $clog2(MAX_VARIANTS) : 1;

    // source row: variant count in the low bits, then the variant list
    localparam int ROW_W = CNT_W + MAX_VARIANTS * OUT_W;

    localparam int TAN_W = 16;
    localparam int TOL_W = 15;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 15;

    localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MORPH_EN  = 2'd1;

    localparam logic [TOL_W-1:0] TOL_RESET = 15'd8;

    typedef enum logic [1:0] {
        ST_OK        = 2'd0,
        ST_OUT_FULL  = 2'd1,
        ST_LIST_FULL = 2'd2
    } t_status;

    // stored frame of one output vertex
    typedef struct packed {
        logic                    sign;
        logic signed [TAN_W-1:0] x;
        logic signed [TAN_W-1:0] y;
        logic signed [TAN_W-1:0] z;
        logic signed [TAN_W-1:0] mx;
        logic signed [TAN_W-1:0] my;
        logic signed [TAN_W-1:0] mz;
    } t_entry;

    localparam int ENT_W = $bits(t_entry);

endpackage

// ----- rtl/tsvs_ram.sv -----
// ----------------------------------------------------------------------------
// tsvs_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module tsvs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- rtl/tangent_seam_vertex_splitter.sv -----
// ----------------------------------------------------------------------------
// tangent_seam_vertex_splitter
// Welds mesh corners into output vertices: a corner reuses an earlier
// variant of its source vertex whose tangent frame matches within the
// tolerance, or else allocates a new output vertex while space remains.
//
//   channel   direction  handshake              payload
//   -------   ---------  ---------------------  ------------------------------
//   corner    in         i_start / o_busy       source vertex, tangent, delta
//   result    out        o_valid (one cycle)    index, new flag, echo, status
//   config    in         i_cfg_valid/o_cfg_ready register index and data
//
// A corner reads its source row, then probes its stored variants in order
// and stops at the first match; when none of them match it goes to the decide step.
// Each variant costs one read of the tangent RAM, one per cycle.
// After reset and after every last corner the variant counts are swept to
// zero, one source row per cycle, with o_busy high.
// Results cannot be stalled; the block holds no more than one corner.
// ----------------------------------------------------------------------------
module tangent_seam_vertex_splitter (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,

    input  logic                                    i_start,
    output logic                                    o_busy,
    input  logic [tsvs_pkg::SRC_W-1:0]              i_source_vertex,
    input  logic signed [tsvs_pkg::TAN_W-1:0]       i_tan_x,
    input  logic signed [tsvs_pkg::TAN_W-1:0]       i_tan_y,
    input  logic signed [tsvs_pkg::TAN_W-1:0]       i_tan_z,
    input  logic                                    i_tan_sign,
    input  logic signed [tsvs_pkg::TAN_W-1:0]       i_morph_dx,
    input  logic signed [tsvs_pkg::TAN_W-1:0]       i_morph_dy,
    input  logic signed [tsvs_pkg::TAN_W-1:0]       i_morph_dz,
    input  logic                                    i_last_corner,

    output logic                                    o_valid,
    output logic [tsvs_pkg::OUT_W-1:0]              o_remapped_index,
    output logic                                    o_is_new,
    output logic [tsvs_pkg::SRC_W-1:0]              o_source_echo,
    output logic [1:0]                              o_status,
    output logic                                    o_mesh_done,

    input  logic                                    i_cfg_valid,
    output logic                                    o_cfg_ready,
    input  logic [tsvs_pkg::CFG_IDX_W-1:0]          i_cfg_index,
    input  logic [tsvs_pkg::CFG_DATA_W-1:0]         i_cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_ROW,
        S_PROBE,
        S_DECIDE
    } t_state;

    function automatic logic near(input logic signed [tsvs_pkg::TAN_W-1:0] a,
                                  input logic signed [tsvs_pkg::TAN_W-1:0] b,
                                  input logic [tsvs_pkg::TOL_W-1:0]        tol);
        logic signed [tsvs_pkg::TAN_W:0] d;
        logic        [tsvs_pkg::TAN_W:0] m;
        d = {a[tsvs_pkg::TAN_W-1], a} - {b[tsvs_pkg::TAN_W-1], b};
        m = d[tsvs_pkg::TAN_W] ? (~d + 1'b1) : d;
        return m <= {{(tsvs_pkg::TAN_W + 1 - tsvs_pkg::TOL_W){1'b0}}, tol};
    endfunction

    t_state                              r_state;
    logic [tsvs_pkg::SRC_W-1:0]          r_clr_addr;
    logic [tsvs_pkg::NF_W-1:0]           r_next_free;
    logic [tsvs_pkg::TOL_W-1:0]          r_tolerance;
    logic                                r_morph_en;

    logic [tsvs_pkg::SRC_W-1:0]          r_src;
    tsvs_pkg::t_entry                    r_item;
    logic                                r_last;
    logic [tsvs_pkg::CNT_W-1:0]          r_cnt;
    logic [tsvs_pkg::OUT_W-1:0]          r_list [tsvs_pkg::MAX_VARIANTS];
    logic [tsvs_pkg::K_W-1:0]            r_k;

    logic                                r_out_valid;
    logic [tsvs_pkg::OUT_W-1:0]          r_out_index;
    logic                                r_out_new;
    logic [tsvs_pkg::SRC_W-1:0]          r_out_src;
    tsvs_pkg::t_status                   r_out_status;
    logic                                r_out_done;

    // memory side
    logic                                row_we;
    logic [tsvs_pkg::SRC_W-1:0]          row_waddr;
    logic [tsvs_pkg::ROW_W-1:0]          row_wdata;
    logic [tsvs_pkg::ROW_W-1:0]          row_rdata;
    logic                                ent_we;
    logic [tsvs_pkg::OUT_W-1:0]          ent_raddr;
    logic [tsvs_pkg::ENT_W-1:0]          ent_rdata;
    tsvs_pkg::t_entry                    ent;

    logic [tsvs_pkg::OUT_W-1:0]          row_list [tsvs_pkg::MAX_VARIANTS];
    logic [tsvs_pkg::CNT_W-1:0]          row_cnt;
    logic [tsvs_pkg::CNT_W-1:0]          k_inc;
    logic [tsvs_pkg::K_W-1:0]            k_next;
    logic                                match;
    logic                                nf_full;
    logic                                alloc;

    assign ent     = tsvs_pkg::t_entry'(ent_rdata);
    assign nf_full = (r_next_free >= tsvs_pkg::NF_W'(tsvs_pkg::MAX_OUT_VERTICES));
    assign alloc   = !nf_full && (r_cnt < tsvs_pkg::CNT_W'(tsvs_pkg::MAX_VARIANTS));
    assign k_inc   = tsvs_pkg::CNT_W'(r_k) + tsvs_pkg::CNT_W'(1);
    assign k_next  = tsvs_pkg::K_W'(k_inc);

    always_comb begin
        for (int k = 0; k < tsvs_pkg::MAX_VARIANTS; k++) begin
            row_list[k] = row_rdata[tsvs_pkg::CNT_W + k * tsvs_pkg::OUT_W +: tsvs_pkg::OUT_W];
        end
        // a stored count never exceeds the list length, clip all the same
        if (row_rdata[tsvs_pkg::CNT_W-1:0] > tsvs_pkg::CNT_W'(tsvs_pkg::MAX_VARIANTS)) begin
            row_cnt = tsvs_pkg::CNT_W'(tsvs_pkg::MAX_VARIANTS);
        end else begin
            row_cnt = row_rdata[tsvs_pkg::CNT_W-1:0];
        end
    end

    always_comb begin
        match = (ent.sign == r_item.sign)
             && near(ent.x, r_item.x, r_tolerance)
             && near(ent.y, r_item.y, r_tolerance)
             && near(ent.z, r_item.z, r_tolerance);
        if (r_morph_en) begin
            match = match
                 && near(ent.mx, r_item.mx, r_tolerance)
                 && near(ent.my, r_item.my, r_tolerance)
                 && near(ent.mz, r_item.mz, r_tolerance);
        end
    end

    // source row write: sweep to zero, or append the new variant
    always_comb begin
        row_wdata = '0;
        row_wdata[tsvs_pkg::CNT_W-1:0] = r_cnt + tsvs_pkg::CNT_W'(1);
        for (int k = 0; k < tsvs_pkg::MAX_VARIANTS; k++) begin
            if (tsvs_pkg::CNT_W'(k) == r_cnt) begin
                row_wdata[tsvs_pkg::CNT_W + k * tsvs_pkg::OUT_W +: tsvs_pkg::OUT_W] =
                    r_next_free[tsvs_pkg::OUT_W-1:0];
            end else begin
                row_wdata[tsvs_pkg::CNT_W + k * tsvs_pkg::OUT_W +: tsvs_pkg::OUT_W] = r_list[k];
            end
        end
        if (r_state == S_CLEAR) begin
            row_wdata = '0;
        end
        row_we    = (r_state == S_CLEAR) || ((r_state == S_DECIDE) && alloc);
        row_waddr = (r_state == S_CLEAR) ? r_clr_addr : r_src;
        ent_we    = (r_state == S_DECIDE) && alloc;
        ent_raddr = (r_state == S_ROW) ? row_list[0] : r_list[k_next];
    end

    tsvs_ram #(
        .WIDTH (tsvs_pkg::ROW_W),
        .DEPTH (tsvs_pkg::MAX_SOURCE_VERTICES)
    ) u_row_ram (
        .i_clk   (i_clk),
        .i_we    (row_we),
        .i_waddr (row_waddr),
        .i_wdata (row_wdata),
        .i_raddr (i_source_vertex),
        .o_rdata (row_rdata)
    );

    tsvs_ram #(
        .WIDTH (tsvs_pkg::ENT_W),
        .DEPTH (tsvs_pkg::MAX_OUT_VERTICES)
    ) u_ent_ram (
        .i_clk   (i_clk),
        .i_we    (ent_we),
        .i_waddr (r_next_free[tsvs_pkg::OUT_W-1:0]),
        .i_wdata (r_item),
        .i_raddr (ent_raddr),
        .o_rdata (ent_rdata)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_next_free <= '0;
            r_tolerance <= tsvs_pkg::TOL_RESET;
            r_morph_en  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_out_valid <= ((r_state == S_PROBE) && match) || (r_state == S_DECIDE);

            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    tsvs_pkg::REG_TOLERANCE: r_tolerance <= i_cfg_data[tsvs_pkg::TOL_W-1:0];
                    tsvs_pkg::REG_MORPH_EN:  r_morph_en  <= i_cfg_data[0];
                    default: ;
                endcase
            end

            unique case (r_state)
                S_CLEAR: begin
                    r_clr_addr <= r_clr_addr + tsvs_pkg::SRC_W'(1);
                    if (r_clr_addr == tsvs_pkg::SRC_W'(tsvs_pkg::MAX_SOURCE_VERTICES - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_start) begin
                        r_src     <= i_source_vertex;
                        r_item.sign <= i_tan_sign;
                        r_item.x  <= i_tan_x;
                        r_item.y  <= i_tan_y;
                        r_item.z  <= i_tan_z;
                        r_item.mx <= i_morph_dx;
                        r_item.my <= i_morph_dy;
                        r_item.mz <= i_morph_dz;
                        r_last    <= i_last_corner;
                        r_state   <= S_ROW;
                    end
                end
                S_ROW: begin
                    r_cnt <= row_cnt;
                    for (int k = 0; k < tsvs_pkg::MAX_VARIANTS; k++) begin
                        r_list[k] <= row_list[k];
                    end
                    r_k     <= '0;
                    r_state <= (row_cnt != '0) ? S_PROBE : S_DECIDE;
                end
                S_PROBE: begin
                    if (match) begin
                        r_out_index  <= r_list[r_k];
                        r_out_new    <= 1'b0;
                        r_out_src    <= r_src;
                        r_out_status <= tsvs_pkg::ST_OK;
                        r_out_done   <= r_last;
                        if (r_last) begin
                            r_next_free <= '0;
                            r_clr_addr  <= '0;
                            r_state     <= S_CLEAR;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end else if (k_inc < r_cnt) begin
                        r_k <= k_next;
                    end else begin
                        r_state <= S_DECIDE;
                    end
                end
                S_DECIDE: begin
                    r_out_src   <= r_src;
                    r_out_done  <= r_last;
                    if (nf_full) begin
                        r_out_index  <= '0;
                        r_out_new    <= 1'b0;
                        r_out_status <= tsvs_pkg::ST_OUT_FULL;
                    end else if (!alloc) begin
                        r_out_index  <= '0;
                        r_out_new    <= 1'b0;
                        r_out_status <= tsvs_pkg::ST_LIST_FULL;
                    end else begin
                        r_out_index  <= r_next_free[tsvs_pkg::OUT_W-1:0];
                        r_out_new    <= 1'b1;
                        r_out_status <= tsvs_pkg::ST_OK;
                        if (!r_last) begin
                            r_next_free <= r_next_free + tsvs_pkg::NF_W'(1);
                        end
                    end
                    if (r_last) begin
                        r_next_free <= '0;
                        r_clr_addr  <= '0;
                        r_state     <= S_CLEAR;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_busy           = (r_state != S_IDLE);
    assign o_cfg_ready      = 1'b1;
    assign o_valid          = r_out_valid;
    assign o_remapped_index = r_out_index;
    assign o_is_new         = r_out_new;
    assign o_source_echo    = r_out_src;
    assign o_status         = r_out_status;
    assign o_mesh_done      = r_out_done;

endmodule
